// ----- rtl/core/ebml_enc_pkg.sv -----
// Types, codes and helper functions for the EBML element encoder.
// Shared by the encoder, serializer and top-level modules; no dependencies.
package ebml_enc_pkg;

  localparam logic [2:0] KIND_UINT  = 3'd0;
  localparam logic [2:0] KIND_SINT  = 3'd1;
  localparam logic [2:0] KIND_FLOAT = 3'd2;
  localparam logic [2:0] KIND_HDR   = 3'd3;
  localparam logic [2:0] KIND_SIZE  = 3'd4;
  localparam logic [2:0] KIND_SSIZE = 3'd5;

  localparam logic [63:0] SZ_LIM1 = 64'h0000_0000_0000_007f;
  localparam logic [63:0] SZ_LIM2 = 64'h0000_0000_0000_3fff;
  localparam logic [63:0] SZ_LIM3 = 64'h0000_0000_001f_ffff;
  localparam logic [63:0] SZ_LIM4 = 64'h0000_0000_0fff_ffff;
  localparam logic [63:0] SZ_LIM5 = 64'h0000_0007_ffff_ffff;
  localparam logic [63:0] SZ_LIM6 = 64'h0000_03ff_ffff_ffff;
  localparam logic [63:0] SZ_LIM7 = 64'h0001_ffff_ffff_ffff;

  localparam logic [7:0] LEN_MARK_1  = 8'h80;
  localparam logic [7:0] LEN_MARK_8  = 8'h01;
  localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id_code;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       error;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [31:0] id;
    logic [2:0]  id_cnt;
    logic [63:0] sz;
    logic [3:0]  sz_cnt;
    logic [63:0] pl;
    logic [3:0]  pl_cnt;
  } run_t;

  function automatic logic [7:0] byte_at(input logic [63:0] word, input logic [2:0] idx);
    byte_at = word[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] id_bytes(input logic [31:0] id);
    logic [2:0] n;
    n = 3'd1;
    for (int k = 1; k < 4; k++) begin
      if ((id >> (8 * k)) != 32'd0) n = 3'(k + 1);
    end
    id_bytes = n;
  endfunction

  function automatic logic [3:0] uint_bytes(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if ((v >> (8 * k)) != 64'd0) n = 4'(k + 1);
    end
    uint_bytes = n;
  endfunction

  function automatic logic [3:0] sint_bytes(input logic [63:0] v);
    logic [3:0]  n;
    logic [63:0] top;
    n = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      top = v >> (8 * k - 1);
      if (top == 64'd0 || top == (ALL_ONES >> (8 * k - 1))) n = 4'(k);
    end
    sint_bytes = n;
  endfunction

  // Length of a biased signed size; 8 means out of range.
  function automatic logic [3:0] ssize_bytes(input logic [63:0] v);
    logic [3:0]  n;
    logic [63:0] top;
    logic [63:0] low;
    n = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      top = v >> (7 * k - 1);
      low = v & ((64'd1 << (7 * k - 1)) - 64'd1);
      if (top == 64'd0 || (top == (ALL_ONES >> (7 * k - 1)) && low != 64'd0)) n = 4'(k);
    end
    ssize_bytes = n;
  endfunction

  function automatic logic [3:0] size_bytes(input logic [63:0] s);
    if (s < SZ_LIM1)      size_bytes = 4'd1;
    else if (s < SZ_LIM2) size_bytes = 4'd2;
    else if (s < SZ_LIM3) size_bytes = 4'd3;
    else if (s < SZ_LIM4) size_bytes = 4'd4;
    else if (s < SZ_LIM5) size_bytes = 4'd5;
    else if (s < SZ_LIM6) size_bytes = 4'd6;
    else if (s < SZ_LIM7) size_bytes = 4'd7;
    else                  size_bytes = 4'd8;
  endfunction

  function automatic logic [63:0] size_word(input logic [63:0] s, input logic [3:0] n);
    if (n == 4'd8) size_word = {LEN_MARK_8, s[55:0]};
    else           size_word = s | (64'd1 << (7 * n));
  endfunction

endpackage

// ----- rtl/core/ebml_enc_encoder.sv -----
// Combinational encoder: splits one request into ID, size and payload segments.
// Depends on ebml_enc_pkg.
module ebml_enc_encoder (
  input  ebml_enc_pkg::in_t  item,
  output ebml_enc_pkg::run_t run
);
  import ebml_enc_pkg::*;

  logic [2:0]  id_len;
  logic [3:0]  u_len;
  logic [3:0]  s_len;
  logic [3:0]  v_len;
  logic [3:0]  n5;
  logic [63:0] s5;
  logic [3:0]  s5_len;

  assign id_len = id_bytes(item.id_code);
  assign u_len  = uint_bytes(item.value);
  assign s_len  = sint_bytes(item.value);
  assign v_len  = size_bytes(item.value);
  assign n5     = ssize_bytes(item.value);
  assign s5     = item.value + ((64'd1 << (7 * n5 - 1)) - 64'd1);
  assign s5_len = size_bytes(s5);

  always_comb begin
    run        = '0;
    run.valid  = 1'b1;
    run.id     = item.id_code;
    run.id_cnt = id_len;
    run.pl     = item.value;
    case (item.kind)
      KIND_UINT: begin
        run.sz     = {56'd0, LEN_MARK_1 | {4'd0, u_len}};
        run.sz_cnt = 4'd1;
        run.pl_cnt = u_len;
      end
      KIND_SINT: begin
        run.sz     = {56'd0, LEN_MARK_1 | {4'd0, s_len}};
        run.sz_cnt = 4'd1;
        run.pl_cnt = s_len;
      end
      KIND_FLOAT: begin
        run.sz     = {56'd0, LEN_MARK_1 | 8'd4};
        run.sz_cnt = 4'd1;
        run.pl     = {32'd0, item.value[31:0]};
        run.pl_cnt = 4'd4;
      end
      KIND_HDR: begin
        run.sz     = size_word(item.value, v_len);
        run.sz_cnt = v_len;
      end
      KIND_SIZE: begin
        run.id_cnt = 3'd0;
        run.sz     = size_word(item.value, v_len);
        run.sz_cnt = v_len;
      end
      KIND_SSIZE: begin
        run.id_cnt = 3'd0;
        if (n5 == 4'd8) begin
          run.err = 1'b1;
        end else begin
          run.sz     = size_word(s5, s5_len);
          run.sz_cnt = s5_len;
        end
      end
      default: begin
        run.valid = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/ebml_enc_serializer.sv -----
// Result register: holds one encoded run and sends it one byte per cycle while out_ready is high.
// Depends on ebml_enc_pkg.
module ebml_enc_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  ebml_enc_pkg::run_t run,
  input  logic               run_valid,
  output logic               run_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ebml_enc_pkg::out_t out_data
);
  import ebml_enc_pkg::*;

  logic        busy_r, busy_nxt;
  logic        err_r, err_nxt;
  logic [31:0] id_r, id_nxt;
  logic [2:0]  id_cnt_r, id_cnt_nxt;
  logic [63:0] sz_r, sz_nxt;
  logic [3:0]  sz_cnt_r, sz_cnt_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [3:0]  pl_cnt_r, pl_cnt_nxt;

  logic [2:0]  id_idx;
  logic [2:0]  sz_idx;
  logic [2:0]  pl_idx;
  logic [4:0]  remain;
  logic        last;
  logic        ack;
  logic [7:0]  cur_byte;

  assign id_idx = id_cnt_r - 3'd1;
  assign sz_idx = sz_cnt_r[2:0] - 3'd1;
  assign pl_idx = pl_cnt_r[2:0] - 3'd1;
  assign remain = {2'b00, id_cnt_r} + {1'b0, sz_cnt_r} + {1'b0, pl_cnt_r};
  assign last   = err_r || (remain == 5'd1);
  assign ack    = busy_r && out_ready;

  always_comb begin
    if (id_cnt_r != 3'd0)      cur_byte = byte_at({32'd0, id_r}, id_idx);
    else if (sz_cnt_r != 4'd0) cur_byte = byte_at(sz_r, sz_idx);
    else if (pl_cnt_r != 4'd0) cur_byte = byte_at(pl_r, pl_idx);
    else                       cur_byte = 8'd0;
  end

  assign run_ready          = !busy_r || (ack && last);
  assign out_valid          = busy_r;
  assign out_data.data_byte = cur_byte;
  assign out_data.last_byte = last;
  assign out_data.error     = err_r;

  always_comb begin
    busy_nxt   = busy_r;
    err_nxt    = err_r;
    id_nxt     = id_r;
    id_cnt_nxt = id_cnt_r;
    sz_nxt     = sz_r;
    sz_cnt_nxt = sz_cnt_r;
    pl_nxt     = pl_r;
    pl_cnt_nxt = pl_cnt_r;
    if (ack) begin
      if (id_cnt_r != 3'd0)      id_cnt_nxt = id_cnt_r - 3'd1;
      else if (sz_cnt_r != 4'd0) sz_cnt_nxt = sz_cnt_r - 4'd1;
      else if (pl_cnt_r != 4'd0) pl_cnt_nxt = pl_cnt_r - 4'd1;
      if (last) busy_nxt = 1'b0;
    end
    if (run_ready && run_valid) begin
      busy_nxt   = 1'b1;
      err_nxt    = run.err;
      id_nxt     = run.id;
      id_cnt_nxt = run.id_cnt;
      sz_nxt     = run.sz;
      sz_cnt_nxt = run.sz_cnt;
      pl_nxt     = run.pl;
      pl_cnt_nxt = run.pl_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      err_r    <= 1'b0;
      id_cnt_r <= '0;
      sz_cnt_r <= '0;
      pl_cnt_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      err_r    <= err_nxt;
      id_cnt_r <= id_cnt_nxt;
      sz_cnt_r <= sz_cnt_nxt;
      pl_cnt_r <= pl_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    sz_r <= sz_nxt;
    pl_r <= pl_nxt;
  end

endmodule

// ----- rtl/core/ebml_element_encoder_core.sv -----
// Each request leaves as a run of one to thirteen bytes, one byte per cycle while
// out_ready is high: the ID bytes (none for bare sizes), the size bytes and the
// payload bytes. A request therefore occupies the byte serializer until its run
// has drained, and that serializer sets the rate. An input register takes the next
// request while the current run drains. Kinds 6 and 7 give no bytes and pass the
// input register without reaching the serializer.
// Top level; depends on ebml_enc_pkg, ebml_enc_encoder and ebml_enc_serializer.
module ebml_element_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebml_enc_pkg::in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ebml_enc_pkg::out_t out_data
);
  import ebml_enc_pkg::*;

  logic in_vld_r, in_vld_nxt;
  in_t  in_r;
  run_t run;
  logic ser_ready;
  logic adv;

  ebml_enc_encoder u_encoder (
    .item (in_r),
    .run  (run)
  );

  ebml_enc_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .run       (run),
    .run_valid (in_vld_r && run.valid),
    .run_ready (ser_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign adv      = in_vld_r && (!run.valid || ser_ready);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) in_vld_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.last_byte && out_data.data_byte == 8'd0)
    else $error("error item must be a single zero byte");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && run.valid && !ser_ready)
    else $error("input stalled without a pending item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_vld_r)
    else $error("reset must leave the block idle");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for ebml_element_encoder_core: directed and random requests, random idling on both
// channels, and a scoreboard that predicts every encoded byte. Depends on ebml_enc_pkg.
module tb_top;
  import ebml_enc_pkg::*;

  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 104;

  class ebml_byte_scoreboard;
    out_t expected_bytes[$];
    logic [7:0] run_bytes[$];
    int mismatches;

    function void add_byte(logic [7:0] b);
      run_bytes.push_back(b);
    endfunction

    function int size_len(logic [63:0] s);
      for (int n = 1; n < 8; n++) begin
        if (s < ((64'd1 << (7 * n)) - 64'd1)) return n;
      end
      return 8;
    endfunction

    function void add_size(logic [63:0] s);
      int n;
      n = size_len(s);
      if (n == 8) begin
        add_byte(8'h01);
        for (int k = 6; k >= 0; k--) add_byte(s[8 * k +: 8]);
      end else begin
        add_byte(s[8 * (n - 1) +: 8] | (8'h80 >> (n - 1)));
        for (int k = n - 2; k >= 0; k--) add_byte(s[8 * k +: 8]);
      end
    endfunction

    function void add_id(logic [31:0] id);
      int n;
      n = 4;
      while (n > 1 && id[8 * (n - 1) +: 8] == 8'h00) n--;
      for (int k = n - 1; k >= 0; k--) add_byte(id[8 * k +: 8]);
    endfunction

    function int uint_len(logic [63:0] v);
      int n;
      n = 8;
      while (n > 1 && v[8 * (n - 1) +: 8] == 8'h00) n--;
      return n;
    endfunction

    function int sint_len(logic [63:0] v);
      int n;
      n = 8;
      while (n > 1) begin
        if (v[63] ? (v[8 * (n - 1) +: 8] == 8'hff && v[8 * (n - 1) - 1])
                  : (v[8 * (n - 1) +: 8] == 8'h00 && !v[8 * (n - 1) - 1]))
          n--;
        else
          break;
      end
      return n;
    endfunction

    function void add_payload(logic [63:0] v, int n);
      add_size(64'(n));
      for (int k = n - 1; k >= 0; k--) add_byte(v[8 * k +: 8]);
    endfunction

    function void note_request(in_t req);
      logic [63:0] v;
      logic [63:0] mag;
      int n;
      bit bad;
      out_t e;
      run_bytes.delete();
      bad = 0;
      v = req.value;
      case (req.kind)
        KIND_UINT: begin
          add_id(req.id_code);
          add_payload(v, uint_len(v));
        end
        KIND_SINT: begin
          add_id(req.id_code);
          add_payload(v, sint_len(v));
        end
        KIND_FLOAT: begin
          add_id(req.id_code);
          add_payload({32'd0, v[31:0]}, 4);
        end
        KIND_HDR: begin
          add_id(req.id_code);
          add_size(v);
        end
        KIND_SIZE: add_size(v);
        KIND_SSIZE: begin
          mag = v[63] ? -v : v;
          if (mag[63]) begin
            bad = 1;
          end else begin
            n = size_len(mag << 1);
            if (n >= 8) bad = 1;
            else add_size(v + ((64'd1 << (7 * n - 1)) - 64'd1));
          end
        end
        default: ;
      endcase
      if (bad) begin
        e.data_byte = 8'h00;
        e.last_byte = 1'b1;
        e.error = 1'b1;
        expected_bytes.push_back(e);
      end else begin
        foreach (run_bytes[k]) begin
          e.data_byte = run_bytes[k];
          e.last_byte = (k == run_bytes.size() - 1);
          e.error = 1'b0;
          expected_bytes.push_back(e);
        end
      end
    endfunction

    function void check_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: data %h last %b error %b",
                   got.data_byte, got.last_byte, got.error);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte || got.last_byte !== want.last_byte ||
          got.error !== want.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"byte mismatch: expected data %h last %b error %b, ",
                    "got data %h last %b error %b"},
                   want.data_byte, want.last_byte, want.error,
                   got.data_byte, got.last_byte, got.error);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  bit idle_en = 1'b1;
  int stall_cycles = 0;
  ebml_byte_scoreboard sb = new();

  ebml_element_encoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_byte(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready = !idle_en || ($urandom_range(99) >= 8);
  end

  task automatic send_request(input logic [2:0] kind, input logic [31:0] id,
                              input logic [63:0] value);
    while (idle_en && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.kind = kind;
    in_data.id_code = id;
    in_data.value = value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(output bit counted);
    logic [2:0] kind;
    logic [31:0] id;
    logic [63:0] value;
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) kind = pick[0] ? KIND_UNUSED_B : KIND_UNUSED_A;
    else kind = 3'($urandom_range(5));
    id = $urandom >> (8 * $urandom_range(3));
    if ($urandom_range(15) == 0) id = '0;
    value = {$urandom, $urandom} >> $urandom_range(63);
    if ((kind == KIND_HDR || kind == KIND_SIZE) && $urandom_range(3) == 0)
      value = (64'd1 << (7 * $urandom_range(1, 8))) - 64'($urandom_range(1, 3));
    if ((kind == KIND_SINT || kind == KIND_SSIZE) && $urandom_range(1)) value = -value;
    if ($urandom_range(31) == 0) value = {$urandom, $urandom};
    counted = (kind != KIND_UNUSED_A && kind != KIND_UNUSED_B);
    send_request(kind, id, value);
  endtask

  initial begin
    int sent;
    bit counted;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(KIND_UINT, 32'h0000_0000, 64'h0);
    send_request(KIND_UINT, 32'h1a45_dfa3, 64'hffff_ffff_ffff_ffff);
    send_request(KIND_UINT, 32'h0000_0080, 64'h100);
    send_request(KIND_SINT, 32'h0000_4286, 64'h0);
    send_request(KIND_SINT, 32'h0000_4286, 64'hffff_ffff_ffff_ffff);
    send_request(KIND_SINT, 32'h0000_0012, 64'h80);
    send_request(KIND_SINT, 32'h0000_0012, 64'hffff_ffff_ffff_ff7f);
    send_request(KIND_SINT, 32'hffff_ffff, 64'h8000_0000_0000_0000);
    send_request(KIND_SINT, 32'h0000_0001, 64'h7fff_ffff_ffff_ffff);
    send_request(KIND_FLOAT, 32'h0000_4489, 64'hdead_beef_3f80_0000);
    send_request(KIND_HDR, 32'h1853_8067, 64'h7e);
    send_request(KIND_HDR, 32'h1f43_b675, 64'h7f);
    send_request(KIND_HDR, 32'h0000_00a3, 64'h3ffe);
    send_request(KIND_HDR, 32'h0000_00a3, 64'h3fff);
    send_request(KIND_HDR, 32'h0000_0000, 64'h0001_ffff_ffff_fffe);
    send_request(KIND_HDR, 32'h0000_0000, 64'h0001_ffff_ffff_ffff);
    send_request(KIND_SIZE, 32'h0, 64'hffff_ffff_ffff_ffff);
    send_request(KIND_SIZE, 32'h0, 64'h0);
    send_request(KIND_SSIZE, 32'h0, 64'h0);
    send_request(KIND_SSIZE, 32'h0, 64'hffff_ffff_ffff_ffff);
    send_request(KIND_SSIZE, 32'h0, 64'h3f);
    send_request(KIND_SSIZE, 32'h0, 64'hffff_ffff_ffff_ffc0);
    send_request(KIND_SSIZE, 32'h0, 64'h8000_0000_0000_0000);
    send_request(KIND_SSIZE, 32'h0, 64'h0080_0000_0000_0000);
    send_request(KIND_UNUSED_A, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(KIND_UNUSED_B, 32'h0, 64'h0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = (sent >= 40);
      send_random(counted);
      if (counted) sent++;
    end
    in_valid = 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
